// ===== rtl/sepv_pkg.sv =====
package sepv_pkg;

  localparam int unsigned VelFracBits = 16;
  localparam logic [29:0] NsPerSecond = 30'd1000000000;
  localparam logic [19:0] NsPerMs     = 20'd1000000;

  localparam logic [2:0] CfgSingleturn = 3'd0;
  localparam logic [2:0] CfgMultiturn  = 3'd1;
  localparam logic [2:0] CfgInvert     = 3'd2;
  localparam logic [2:0] CfgCenter     = 3'd3;
  localparam logic [2:0] CfgHasReset   = 3'd4;
  localparam logic [2:0] CfgPulseMs    = 3'd5;

  typedef struct packed {
    logic data_error;
    logic frame_error;
    logic power_failure;
    logic data_mismatch;
    logic sync_error;
    logic enc_unready;
    logic pdo_toggle;
  } status_t;

endpackage

// ===== rtl/ssi_encoder_position_velocity.sv =====
// SSI absolute encoder position and velocity. One transaction per fieldbus
// cycle: the raw count is masked to singleturn+multiturn bits (max 32),
// optionally inverted and centered on zero, scaled to revolutions (Q(63-F).F,
// F = POSITION_FRACTION_BITS) and added to a kept offset with saturation.
// Velocity (Q47.16 rev/s) is the position delta times 1e9 divided by the time
// delta; zero delta gives zero. Overrides either set the offset at once or
// pulse the reset pin until the count reads zero (success) or twice the pulse
// time passes (failure). From the accepting edge to out_valid_o the steps are:
// the bit-serial pulse-length multiply; scale, sum and difference; the
// bit-serial 1e9 multiply; the restoring divider that retires one quotient
// bit per cycle; and override, reset pin and output load. One transaction
// is in flight at a time; the output register frees the input side as soon
// as the result is loaded, so a new transaction can be taken only then, and
// not while the output stalls.
module ssi_encoder_position_velocity #(
  parameter int unsigned POSITION_FRACTION_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [2:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           ssi_count_i,
  input  logic [7:0]            status_byte_i,
  input  logic [63:0]           time_ns_i,
  input  logic                  override_request_i,
  input  logic signed [63:0]    override_position_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [63:0]    pos_revs_o,
  output logic signed [63:0]    velocity_rps_o,
  output logic                  data_error_o,
  output logic                  frame_error_o,
  output logic                  power_failure_o,
  output logic                  data_mismatch_o,
  output logic                  sync_error_o,
  output logic                  enc_unready_o,
  output logic                  pdo_toggle_o,
  output logic                  reset_pin_o,
  output logic                  override_busy_o,
  output logic                  override_succeeded_o
);
  import sepv_pkg::*;

  localparam int unsigned ShiftS = POSITION_FRACTION_BITS - VelFracBits;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StCount = 4'd1;
  localparam logic [3:0] StScale = 4'd2;
  localparam logic [3:0] StSum   = 4'd3;
  localparam logic [3:0] StDiff  = 4'd4;
  localparam logic [3:0] StMul   = 4'd5;
  localparam logic [3:0] StDiv   = 4'd6;
  localparam logic [3:0] StOvr   = 4'd7;
  localparam logic [3:0] StOut   = 4'd8;
  localparam logic [3:0] StPulse = 4'd9;

  logic [3:0]  state_q, state_d;

  // configuration
  logic [5:0]  st_bits_q, mt_bits_q;
  logic        invert_q, center_q, has_reset_q;
  logic [15:0] pulse_ms_q;

  // kept state
  logic signed [63:0] offset_q, prev_pos_q, target_q;
  logic [63:0] prev_time_q, start_time_q;
  logic        busy_q, success_q, level_q;

  // per-transaction registers
  logic [31:0] raw_q;
  logic [63:0] now_q, dt_q, pulse_ns_q;
  logic        req_q;
  logic signed [63:0] req_pos_q;
  logic signed [33:0] cnt_q;
  logic signed [63:0] before_q, pos_q;
  logic        neg_q;
  logic [63:0] mag_q;
  logic [93:0] num_q;
  logic [29:0] mul_sh_q;
  logic [4:0]  mul_cnt_q;
  logic [93:0] rem_q;
  logic [127:0] quo_q;
  logic [7:0]  div_cnt_q;
  logic [4:0]  pul_cnt_q;

  // output register
  logic        out_valid_q;
  logic signed [63:0] pos_out_q, vel_out_q;
  status_t     status_q;
  logic        pin_q, busy_out_q, succ_out_q;

  logic [5:0] st_eff, mt_eff, len;
  logic [6:0] len_sum;
  logic [32:0] full;
  logic [31:0] masked;
  logic signed [33:0] c1, c2;
  logic        in_accept;

  always_comb begin
    st_eff  = (st_bits_q > 6'd32) ? 6'd32 : st_bits_q;
    mt_eff  = (mt_bits_q > 6'd32) ? 6'd32 : mt_bits_q;
    len_sum = {1'b0, st_eff} + {1'b0, mt_eff};
    len     = (len_sum > 7'd32) ? 6'd32 : len_sum[5:0];
    full    = 33'd1 << len;
    masked  = raw_q & 32'(full - 33'd1);
    c1 = invert_q ? (34'($signed({1'b0, full})) - 34'($signed({2'b0, masked})))
                  : 34'($signed({2'b0, masked}));
    c2 = (center_q && (c1 >= 34'($signed({2'b0, full[32:1]}))))
           ? c1 - 34'($signed({1'b0, full})) : c1;
  end

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && !in_stall_o;

  // saturating helpers
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg,
                                                  input logic [63:0] m);
    if (!neg) return m[63] ? 64'sh7FFF_FFFF_FFFF_FFFF : $signed(m);
    if (m[63]) return 64'sh8000_0000_0000_0000;
    return -$signed(m);
  endfunction

  // scaling
  logic [6:0]  shamt_up, shamt_dn;
  logic        scale_up;
  logic [33:0] cmag;
  logic        cneg;
  logic [97:0] up_val;
  logic [33:0] dn_val;
  logic signed [63:0] scaled;

  always_comb begin
    cneg     = cnt_q[33];
    cmag     = cneg ? 34'(-cnt_q) : 34'(cnt_q);
    scale_up = (7'(POSITION_FRACTION_BITS) >= {1'b0, st_eff});
    shamt_up = 7'(POSITION_FRACTION_BITS) - {1'b0, st_eff};
    shamt_dn = {1'b0, st_eff} - 7'(POSITION_FRACTION_BITS);
    up_val   = {64'd0, cmag} << shamt_up;
    dn_val   = cneg ? 34'((35'(cmag) + ((35'd1 << shamt_dn) - 35'd1)) >> shamt_dn)
                    : (cmag >> shamt_dn);
    if (scale_up) begin
      scaled = (up_val[97:64] != 34'd0) ? (cneg ? 64'sh8000_0000_0000_0000
                                               : 64'sh7FFF_FFFF_FFFF_FFFF)
                                        : from_mag(cneg, up_val[63:0]);
    end else begin
      scaled = from_mag(cneg, {30'd0, dn_val});
    end
  end

  // divider step: denominator dt << ShiftS (up to 64+ShiftS bits)
  logic [127:0] den;
  logic [94:0]  rem_sh;
  logic [127:0] rem_cmp;
  logic         fits;
  logic [6:0]   bit_idx;

  always_comb begin
    den     = {64'd0, dt_q} << ShiftS;
    bit_idx = 7'(8'd127 - div_cnt_q);
    rem_sh  = {rem_q, (bit_idx < 7'd94) ? num_q[bit_idx] : 1'b0};
    rem_cmp = {33'd0, rem_sh};
    fits    = (rem_cmp >= den);
  end

  logic [63:0] elapsed;
  logic [64:0] twice;
  assign elapsed = now_q - start_time_q;
  assign twice   = {pulse_ns_q, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      st_bits_q    <= 6'd12;
      mt_bits_q    <= 6'd12;
      invert_q     <= 1'b0;
      center_q     <= 1'b0;
      has_reset_q  <= 1'b1;
      pulse_ms_q   <= 16'd100;
      offset_q     <= '0;
      prev_pos_q   <= '0;
      target_q     <= '0;
      prev_time_q  <= '0;
      start_time_q <= '0;
      busy_q       <= 1'b0;
      success_q    <= 1'b0;
      level_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgSingleturn: st_bits_q   <= cfg_data_i[5:0];
          CfgMultiturn:  mt_bits_q   <= cfg_data_i[5:0];
          CfgInvert:     invert_q    <= cfg_data_i[0];
          CfgCenter:     center_q    <= cfg_data_i[0];
          CfgHasReset:   has_reset_q <= cfg_data_i[0];
          CfgPulseMs:    pulse_ms_q  <= cfg_data_i;
          default: ;
        endcase
      end
      // load a new result, else drop the one taken by the receiver
      if (state_q == StOut && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            raw_q      <= ssi_count_i;
            now_q      <= time_ns_i;
            req_q      <= override_request_i;
            req_pos_q  <= override_position_i;
            status_q   <= '{status_byte_i[0], status_byte_i[1], status_byte_i[2],
                            status_byte_i[3], status_byte_i[5], status_byte_i[6],
                            status_byte_i[7]};
            pulse_ns_q <= '0;
            pul_cnt_q  <= '0;
          end
        end
        StCount: begin
          cnt_q <= c2;
          // serial pulse_ms * 1e6, MSB first: one multiplier bit per cycle
          if (pulse_ms_q[4'd15 - pul_cnt_q[3:0]])
            pulse_ns_q <= {pulse_ns_q[62:0], 1'b0} + 64'(NsPerMs);
          else
            pulse_ns_q <= {pulse_ns_q[62:0], 1'b0};
          pul_cnt_q <= pul_cnt_q + 5'd1;
        end
        StScale: begin
          before_q <= scaled;
        end
        StSum: begin
          pos_q <= sat_add(before_q, offset_q);
          dt_q  <= now_q - prev_time_q;
        end
        StDiff: begin
          neg_q     <= (pos_q < prev_pos_q);
          mag_q     <= (pos_q >= prev_pos_q) ? 64'(pos_q) - 64'(prev_pos_q)
                                             : 64'(prev_pos_q) - 64'(pos_q);
          num_q     <= '0;
          mul_sh_q  <= NsPerSecond;
          mul_cnt_q <= '0;
        end
        StMul: begin
          // shift-add: one bit of 1e9 per cycle
          if (mul_sh_q[0]) num_q <= num_q + (94'(mag_q) << mul_cnt_q);
          mul_sh_q  <= mul_sh_q >> 1;
          mul_cnt_q <= mul_cnt_q + 5'd1;
          rem_q     <= '0;
          quo_q     <= '0;
          div_cnt_q <= '0;
        end
        StDiv: begin
          if (fits) rem_q <= 94'(rem_cmp - den);
          else      rem_q <= rem_sh[93:0];
          quo_q     <= {quo_q[126:0], fits};
          div_cnt_q <= div_cnt_q + 8'd1;
        end
        StOvr: begin
          prev_time_q <= now_q;
          prev_pos_q  <= pos_q;
          pos_out_q   <= pos_q;
          if (dt_q == 64'd0)          vel_out_q <= '0;
          else if (quo_q[127:64] != 64'd0)
            vel_out_q <= neg_q ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
          else vel_out_q <= from_mag(neg_q, quo_q[63:0]);
          if (req_q) begin
            target_q <= req_pos_q;
            busy_q   <= 1'b1;
            if (has_reset_q) begin
              level_q      <= 1'b1;
              start_time_q <= now_q;
            end else begin
              offset_q  <= sat_sub(req_pos_q, before_q);
              busy_q    <= 1'b0;
              success_q <= 1'b1;
            end
          end
        end
        StPulse: begin
          if (busy_q) begin
            vel_out_q <= '0;
            level_q   <= (elapsed < pulse_ns_q);
            if (raw_q == 32'd0) begin
              busy_q    <= 1'b0;
              success_q <= 1'b1;
              offset_q  <= target_q;
              pos_out_q <= target_q;
              level_q   <= 1'b0;
            end else if ({1'b0, elapsed} > twice) begin
              busy_q    <= 1'b0;
              success_q <= 1'b0;
              level_q   <= 1'b0;
            end
          end
        end
        StOut: begin
          if (!out_valid_q || !out_stall_i) begin
            pin_q       <= level_q;
            busy_out_q  <= busy_q;
            succ_out_q  <= success_q;
            pos_revs_o     <= pos_out_q;
            velocity_rps_o <= vel_out_q;
            {data_error_o, frame_error_o, power_failure_o, data_mismatch_o,
             sync_error_o, enc_unready_o, pdo_toggle_o} <= status_q;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  if (in_accept) state_d = StCount;
      StCount: if (pul_cnt_q == 5'd15) state_d = StScale;
      StScale: state_d = StSum;
      StSum:   state_d = StDiff;
      StDiff:  state_d = StMul;
      StMul:   if (mul_cnt_q == 5'd29) state_d = StDiv;
      StDiv:   if (div_cnt_q == 8'd127) state_d = StOvr;
      StOvr:   state_d = StPulse;
      StPulse: state_d = StOut;
      StOut:   if (!out_valid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign reset_pin_o          = pin_q;
  assign override_busy_o      = busy_out_q;
  assign override_succeeded_o = succ_out_q;

endmodule
